FILE: rtl/core/pcb_pkg.sv
// ----------------------------------------------------------------------------
// pcb_pkg - shared types and constants for the pixel cross-fade blender
// Mode codes, register indexes, field masks and the divide-by-255 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pcb_pkg;

  localparam int WORD_W     = 32;
  localparam int HALF_W     = 16;
  localparam int NUM_HALF   = WORD_W / HALF_W;
  localparam int CHAN_W     = 8;
  localparam int SUM_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 2;
  localparam int NUM_CHAN   = 3;

  // pixel_mode codes; the spare code decodes as byte mode
  localparam logic [MODE_W-1:0] MODE_BYTE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGB565 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RGB555 = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_AMOUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_KEY = 2'd2;

  localparam logic [MODE_W-1:0]     PIXEL_MODE_RST      = MODE_BYTE;
  localparam logic [CHAN_W-1:0]     BLEND_AMOUNT_RST    = 8'd0;
  localparam logic [HALF_W-1:0]     TRANSPARENT_KEY_RST = 16'h39CE;

  localparam logic [CHAN_W-1:0] FULL_WEIGHT = 8'd255;
  localparam logic [HALF_W-1:0] SET_BIT15   = 16'h8000;

  // which bytes of a 16-bit lane exist for the configured word size
  typedef struct packed {
    logic lo_byte;
    logic hi_byte;
  } lane_en_t;

  // floor(x / 255), exact for x up to 255*255
  function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
    logic [SUM_W:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[SUM_W-1:CHAN_W]};
    return t[SUM_W-1:CHAN_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcb_if.sv
// ----------------------------------------------------------------------------
// pcb_if - channel interfaces for the pixel cross-fade blender
// Input word pair, blended output word and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_a;
  logic [31:0] word_b;

  modport source (output valid, output word_a, output word_b, input ready);
  modport sink   (input valid, input word_a, input word_b, output ready);
endinterface

interface pcb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mixed_word;

  modport source (output valid, output mixed_word, input ready);
  modport sink   (input valid, input mixed_word, output ready);
endinterface

interface pcb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pcb_lane.sv
// ----------------------------------------------------------------------------
// pcb_lane - one 16-bit blend lane
// Three channel multipliers feed a register; the divide by 255 and the
// repacking for byte, rgb565 and rgb555 modes follow it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_lane
  import pcb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire lane_en_t          lane_en,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [CHAN_W-1:0] weight,
  input  wire logic [HALF_W-1:0] key,
  input  wire logic [HALF_W-1:0] pix_a,
  input  wire logic [HALF_W-1:0] pix_b,
  output logic      [HALF_W-1:0] mixed
);

  logic [CHAN_W-1:0] chan_a [NUM_CHAN];
  logic [CHAN_W-1:0] chan_b [NUM_CHAN];
  logic [SUM_W-1:0]  sum_next [NUM_CHAN];
  logic [CHAN_W-1:0] inv_w;

  // stage registers
  logic [SUM_W-1:0]  sum [NUM_CHAN];
  logic [MODE_W-1:0] mode_q;
  logic              a_is_key;
  logic              b_is_key;
  logic [HALF_W-1:0] pix_a_q;
  logic [HALF_W-1:0] pix_b_q;

  logic [CHAN_W-1:0] q [NUM_CHAN];
  logic [HALF_W-1:0] packed_pix;

  assign inv_w = FULL_WEIGHT - weight;

  // channel split by mode
  always_comb begin
    unique case (mode)
      MODE_RGB565: begin
        chan_a[0] = {3'd0, pix_a[4:0]};
        chan_a[1] = {2'd0, pix_a[10:5]};
        chan_a[2] = {3'd0, pix_a[15:11]};
        chan_b[0] = {3'd0, pix_b[4:0]};
        chan_b[1] = {2'd0, pix_b[10:5]};
        chan_b[2] = {3'd0, pix_b[15:11]};
      end
      MODE_RGB555: begin
        chan_a[0] = {3'd0, pix_a[4:0]};
        chan_a[1] = {3'd0, pix_a[9:5]};
        chan_a[2] = {3'd0, pix_a[14:10]};
        chan_b[0] = {3'd0, pix_b[4:0]};
        chan_b[1] = {3'd0, pix_b[9:5]};
        chan_b[2] = {3'd0, pix_b[14:10]};
      end
      default: begin
        chan_a[0] = pix_a[7:0];
        chan_a[1] = pix_a[15:8];
        chan_a[2] = '0;
        chan_b[0] = pix_b[7:0];
        chan_b[1] = pix_b[15:8];
        chan_b[2] = '0;
      end
    endcase
  end

  // a*(255-w) + b*w never exceeds 255*255
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum_next[c] = SUM_W'({8'd0, chan_a[c]} * {8'd0, inv_w})
                  + SUM_W'({8'd0, chan_b[c]} * {8'd0, weight});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        sum[c] <= sum_next[c];
      end
      mode_q   <= mode;
      a_is_key <= (pix_a == key);
      b_is_key <= (pix_b == key);
      pix_a_q  <= pix_a;
      pix_b_q  <= pix_b;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      q[c] = div255(sum[c]);
    end
  end

  // repack; in rgb555 mode a keyed first pixel wins over a keyed second
  always_comb begin
    unique case (mode_q)
      MODE_RGB565: begin
        packed_pix = {q[2][4:0], q[1][5:0], q[0][4:0]};
        if (!lane_en.hi_byte) begin
          packed_pix = '0;
        end
      end
      MODE_RGB555: begin
        if (a_is_key) begin
          packed_pix = pix_b_q;
        end else if (b_is_key) begin
          packed_pix = pix_a_q;
        end else begin
          packed_pix = SET_BIT15 | {1'b0, q[2][4:0], q[1][4:0], q[0][4:0]};
        end
        if (!lane_en.hi_byte) begin
          packed_pix = '0;
        end
      end
      default: begin
        packed_pix = {q[1] & {CHAN_W{lane_en.hi_byte}},
                      q[0] & {CHAN_W{lane_en.lo_byte}}};
      end
    endcase
  end

  assign mixed = packed_pix;

endmodule

`default_nettype wire

FILE: rtl/core/pixel_crossfade_blend_top.sv
// ----------------------------------------------------------------------------
// pixel_crossfade_blend_top - two-image cross-fade, one 32-bit word a beat
// Lane array with a registered multiply stage and an output register.
// ----------------------------------------------------------------------------
// Cross-fades two images one 32-bit word per beat: every channel becomes
// (a*(255-blend_amount) + b*blend_amount)/255, truncated. pixel_mode selects
// four byte channels (code 0, and the spare code 3), two rgb565 pixels (1) or
// two rgb555 pixels with bit 15 forced and a transparent key (2). The block
// takes one word pair per clock and sustains one result per clock while the
// output is not stalled. The pipeline has two stages: the multiply register
// loads at the accepting edge and the output register loads from it once
// the output register is free. A stalled output holds the output register;
// the input side takes at most one more beat into the multiply stage and
// then drops ready until the output moves. WORD_BYTES below four leaves the
// missing byte lanes at zero; an odd count in a pixel mode zeroes the whole
// 16-bit half that holds no whole pixel. Register writes are always ready and
// should only be issued while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_crossfade_blend_top
  import pcb_pkg::*;
#(
  parameter int WORD_BYTES = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  pcb_in_if.sink    pix_in,
  pcb_out_if.source pix_out,
  pcb_cfg_if.sink   cfg
);

  // lanes beyond the 32-bit word carry nothing
  localparam int LANE_BYTES = (WORD_BYTES > WORD_W / 8) ? WORD_W / 8 : WORD_BYTES;

  // configuration registers
  logic [MODE_W-1:0] pixel_mode;
  logic [CHAN_W-1:0] blend_amount;
  logic [HALF_W-1:0] transparent_key;

  // pipeline control
  logic              s1_valid;
  logic              out_valid;
  logic              s1_adv;
  logic              in_ready;
  logic [WORD_W-1:0] mixed_next;
  logic [WORD_W-1:0] mixed_word;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode      <= PIXEL_MODE_RST;
      blend_amount    <= BLEND_AMOUNT_RST;
      transparent_key <= TRANSPARENT_KEY_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PIXEL_MODE:      pixel_mode      <= cfg.data[MODE_W-1:0];
        REG_BLEND_AMOUNT:    blend_amount    <= cfg.data[CHAN_W-1:0];
        REG_TRANSPARENT_KEY: transparent_key <= cfg.data;
        default: ;  // no register at this index
      endcase
    end
  end

  // output register frees when empty or taken this cycle
  assign s1_adv   = !out_valid || pix_out.ready;
  assign in_ready = !s1_valid || s1_adv;
  assign pix_in.ready = in_ready;

  // lane array: each lane owns one 16-bit half of the word
  for (genvar h = 0; h < NUM_HALF; h++) begin : g_lane
    lane_en_t lane_en;

    assign lane_en.lo_byte = (2 * h < LANE_BYTES);
    assign lane_en.hi_byte = (2 * h + 1 < LANE_BYTES);

    pcb_lane u_lane (
      .clk    (clk),
      .en     (in_ready),
      .lane_en(lane_en),
      .mode   (pixel_mode),
      .weight (blend_amount),
      .key    (transparent_key),
      .pix_a  (pix_in.word_a[h*HALF_W +: HALF_W]),
      .pix_b  (pix_in.word_b[h*HALF_W +: HALF_W]),
      .mixed  (mixed_next[h*HALF_W +: HALF_W])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= pix_in.valid;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  // merge: lanes land side by side in the output register
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      mixed_word <= mixed_next;
    end
  end

  assign pix_out.valid      = out_valid;
  assign pix_out.mixed_word = mixed_word;

endmodule

`default_nettype wire
